[rtl/core/meter_autorange_controller_assert.svh]
// assertion macros for the meter autorange controller
`ifndef METER_AUTORANGE_CONTROLLER_ASSERT_SVH
`define METER_AUTORANGE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define MAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("autorange check failed");
`define MAR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("autorange check failed");
`else
`define MAR_ASSERT_IMP(lbl, ante, cons)
`define MAR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/mar_pkg.sv]
// types and constants shared by the meter autorange controller
`default_nettype none
package mar_pkg;

  localparam int READING_BITS_DEF  = 24;
  localparam int MAX_GAIN_STEP_DEF = 3;
  localparam int RMS_W             = 24;
  localparam int CFG_DATA_W        = 18;
  localparam int CFG_INDEX_W       = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HEAD    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HEAD    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_AVERAGE = 2'd3;

  localparam logic [17:0] FREQ_RESET     = 18'd1000;
  localparam logic [13:0] MIN_HEAD_RESET = 14'd256;
  localparam logic [13:0] MAX_HEAD_RESET = 14'd4096;

  localparam logic [17:0] FREQ_KNEE = 18'd40000;
  localparam logic [17:0] FREQ_TOP  = 18'd11000;
  localparam logic signed [31:0] HEAD_SCALE = 32'sd3125;

  localparam logic [31:0] BOUND_450   = 32'd450;
  localparam logic [31:0] BOUND_550   = 32'd550;
  localparam logic [31:0] BOUND_4500  = 32'd4500;
  localparam logic [31:0] BOUND_5500  = 32'd5500;
  localparam logic [31:0] BOUND_45000 = 32'd45000;
  localparam logic [31:0] BOUND_55000 = 32'd55000;

  localparam logic [1:0] RANGE_100R = 2'd0;
  localparam logic [1:0] RANGE_1K   = 2'd1;
  localparam logic [1:0] RANGE_10K  = 2'd2;
  localparam logic [1:0] RANGE_100K = 2'd3;

  localparam logic [1:0] STAT_NONE     = 2'd0;
  localparam logic [1:0] STAT_STARTED  = 2'd1;
  localparam logic [1:0] STAT_ACTIVE   = 2'd2;
  localparam logic [1:0] STAT_FINISHED = 2'd3;

  typedef struct packed {
    logic signed [15:0] volt_headroom;
    logic signed [15:0] curr_headroom;
    logic [RMS_W-1:0]   volt_rms;
    logic [RMS_W-1:0]   curr_rms;
    logic               hold_range;
    logic               force_start;
  } mar_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] volt_gain_out;
    logic [1:0] curr_gain_out;
    logic [1:0] imp_range_out;
    logic       set_averaging;
    logic       reset_readings;
  } mar_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mar_div_st_t;

  typedef struct packed {
    logic busy;
    logic v_low;
    logic v_high;
    logic c_low;
    logic c_high;
  } mar_head_st_t;

endpackage
`default_nettype wire

[rtl/core/mar_div.sv]
// restoring divider, one quotient bit per cycle through a shift register
`default_nettype none
module mar_div #(
  parameter int VB = mar_pkg::READING_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VB-1:0]    dividend,
  input  wire logic [VB-1:0]    divisor,
  output logic [VB-1:0]         quotient,
  output mar_pkg::mar_div_st_t  st
);

  localparam int CW = $clog2(VB + 1);

  logic [VB-1:0] rem_r, rem_nxt;
  logic [VB-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VB:0]   shifted;
  logic [VB+1:0] trial;

  assign shifted = {rem_r, quo_r[VB-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(VB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[VB+1]) begin
        rem_nxt = shifted[VB-1:0];
        quo_nxt = {quo_r[VB-2:0], 1'b0};
      end else begin
        rem_nxt = trial[VB-1:0];
        quo_nxt = {quo_r[VB-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = quo_r;
  assign st.busy  = busy_r;
  assign st.done  = done_r;

endmodule
`default_nettype wire

[rtl/core/mar_head.sv]
// headroom window check, one limit compare per cycle over four steps
`default_nettype none
module mar_head (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] volt_headroom,
  input  wire logic signed [15:0] curr_headroom,
  input  wire logic [17:0]        frequency_hz,
  input  wire logic [13:0]        min_headroom,
  input  wire logic [13:0]        max_headroom,
  output mar_pkg::mar_head_st_t   st
);

  logic [1:0]         step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic [3:0]         flag_r, flag_nxt;
  logic signed [15:0] head;
  logic [13:0]        lim;
  logic signed [31:0] diff;
  logic signed [31:0] lhs;
  logic signed [31:0] dnum;
  logic               hit;

  assign dnum = (frequency_hz > mar_pkg::FREQ_KNEE)
              ? $signed({7'd0, frequency_hz - mar_pkg::FREQ_KNEE, 7'd0}) : 32'sd0;

  // step bit 1 picks the channel, bit 0 the upper limit
  assign head = step_r[1] ? curr_headroom : volt_headroom;
  assign lim  = step_r[0] ? max_headroom : min_headroom;
  assign diff = $signed({{16{head[15]}}, head}) - $signed({18'd0, lim});
  assign lhs  = diff * mar_pkg::HEAD_SCALE;
  assign hit  = step_r[0] ? (lhs > dnum) : (lhs < dnum);

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    flag_nxt = flag_r;
    if (start) begin
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      flag_nxt[step_r] = hit;
      step_nxt = step_r + 1'b1;
      if (step_r == 2'd3) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    flag_r <= flag_nxt;
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign st.busy   = busy_r;
  assign st.v_low  = flag_r[0];
  assign st.v_high = flag_r[1];
  assign st.c_low  = flag_r[2];
  assign st.c_high = flag_r[3];

endmodule
`default_nettype wire

[rtl/core/meter_autorange_controller.sv]
// meter autorange controller top level
//
// Usage: one measurement report enters per transaction on the in_ channel
// (in_valid/in_stall) and yields exactly one result transaction on the out_
// channel (out_valid/out_stall). Limits and frequency are written through the
// cfg_ port (cfg_we, cfg_index, cfg_data); the user must write them only while no
// transaction is in flight, and the block itself does not enforce this.
// The result is registered once the VB-bit bit-serial divider that forms
// volt_rms/curr_rms one quotient bit per cycle is done, VB being READING_BITS
// capped at the 24-bit reading width; the four headroom compares share one
// comparator and finish while the divider runs. in_stall stays high from
// acceptance until the result is written to the output register, so a new
// report is taken only after the last result is written.
// A result waiting in the output register does not block the next report;
// if out_stall holds it, the following result waits in place and the
// controller state is updated only when that result is written.
// Reset (synchronous, rst_n low): gains and impedance range go to zero,
// ranging is off, the registers take their reset values, no result is valid.
`default_nettype none
module meter_autorange_controller #(
  parameter int READING_BITS  = mar_pkg::READING_BITS_DEF,
  parameter int MAX_GAIN_STEP = mar_pkg::MAX_GAIN_STEP_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire mar_pkg::mar_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output mar_pkg::mar_out_t                       out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mar_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mar_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VB = (READING_BITS < mar_pkg::RMS_W) ? READING_BITS : mar_pkg::RMS_W;
  localparam int GW = $clog2(MAX_GAIN_STEP + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  mar_pkg::mar_in_t      item_r;
  logic [17:0]           freq_r;
  logic [13:0]           min_head_r;
  logic [13:0]           max_head_r;
  logic [GW-1:0]         vgain_r, vgain_nxt;
  logic [GW-1:0]         cgain_r, cgain_nxt;
  logic [1:0]            range_r, range_nxt;
  logic                  ranging_on_r, ranging_on_nxt;
  logic                  out_valid_r;
  mar_pkg::mar_out_t     out_data_r, out_data_nxt;

  logic                  in_accept;
  logic                  commit;
  mar_pkg::mar_div_st_t  div_st;
  mar_pkg::mar_head_st_t head_st;
  logic [VB-1:0]         quotient;
  logic [31:0]           qz;
  logic                  nz;
  logic                  b450, b550, b4500, b5500, b45000, b55000;
  logic [1:0]            want;
  logic                  vchg, cchg, rchg, changed;
  logic [1:0]            status;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign commit    = (state_r == ST_COMMIT) && (!out_valid_r || !out_stall);

  mar_div #(.VB(VB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .dividend (in_data.volt_rms[VB-1:0]),
    .divisor  (item_r.curr_rms[VB-1:0]),
    .quotient (quotient),
    .st       (div_st)
  );

  mar_head u_head (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (in_accept),
    .volt_headroom (item_r.volt_headroom),
    .curr_headroom (item_r.curr_headroom),
    .frequency_hz  (freq_r),
    .min_headroom  (min_head_r),
    .max_headroom  (max_head_r),
    .st            (head_st)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (div_st.done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // gain steps
  always_comb begin
    vgain_nxt = vgain_r;
    vchg      = 1'b0;
    if (head_st.v_low && vgain_r != '0) begin
      vgain_nxt = vgain_r - 1'b1;
      vchg      = 1'b1;
    end else if (head_st.v_high && vgain_r < GW'(MAX_GAIN_STEP)) begin
      vgain_nxt = vgain_r + 1'b1;
      vchg      = 1'b1;
    end
    cgain_nxt = cgain_r;
    cchg      = 1'b0;
    if (head_st.c_low && cgain_r != '0) begin
      cgain_nxt = cgain_r - 1'b1;
      cchg      = 1'b1;
    end else if (head_st.c_high && cgain_r < GW'(MAX_GAIN_STEP)) begin
      cgain_nxt = cgain_r + 1'b1;
      cchg      = 1'b1;
    end
  end

  // impedance bands, zero current reads as the top of the scale
  assign qz     = 32'(quotient);
  assign nz     = (item_r.curr_rms[VB-1:0] != '0);
  assign b450   = nz && (qz < mar_pkg::BOUND_450);
  assign b550   = nz && (qz < mar_pkg::BOUND_550);
  assign b4500  = nz && (qz < mar_pkg::BOUND_4500);
  assign b5500  = nz && (qz < mar_pkg::BOUND_5500);
  assign b45000 = nz && (qz < mar_pkg::BOUND_45000);
  assign b55000 = nz && (qz < mar_pkg::BOUND_55000);

  always_comb begin
    want = range_r;
    if (b450) begin
      want = mar_pkg::RANGE_100R;
    end else if (b550) begin
      if (range_r == mar_pkg::RANGE_10K || range_r == mar_pkg::RANGE_100K) begin
        want = mar_pkg::RANGE_100R;
      end
    end else if (b4500) begin
      want = mar_pkg::RANGE_1K;
    end else if (b5500) begin
      if (range_r != mar_pkg::RANGE_1K && range_r != mar_pkg::RANGE_10K) begin
        want = mar_pkg::RANGE_1K;
      end
    end else if (b45000) begin
      want = mar_pkg::RANGE_10K;
    end else if (b55000) begin
      if (range_r == mar_pkg::RANGE_100R || range_r == mar_pkg::RANGE_1K) begin
        want = mar_pkg::RANGE_10K;
      end
    end else begin
      want = (freq_r > mar_pkg::FREQ_TOP) ? mar_pkg::RANGE_10K : mar_pkg::RANGE_100K;
    end
  end

  assign rchg      = !item_r.hold_range && (want != range_r);
  assign range_nxt = rchg ? want : range_r;
  assign changed   = vchg || cchg || rchg;

  always_comb begin
    status         = mar_pkg::STAT_NONE;
    ranging_on_nxt = ranging_on_r;
    if (item_r.force_start || (!ranging_on_r && changed)) begin
      status         = mar_pkg::STAT_STARTED;
      ranging_on_nxt = 1'b1;
    end else if (ranging_on_r && changed) begin
      status = mar_pkg::STAT_ACTIVE;
    end else if (ranging_on_r) begin
      status         = mar_pkg::STAT_FINISHED;
      ranging_on_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt.status         = status;
    out_data_nxt.volt_gain_out  = 2'(vgain_nxt);
    out_data_nxt.curr_gain_out  = 2'(cgain_nxt);
    out_data_nxt.imp_range_out  = range_nxt;
    out_data_nxt.set_averaging  = (status == mar_pkg::STAT_STARTED);
    out_data_nxt.reset_readings = (status == mar_pkg::STAT_ACTIVE);
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      freq_r       <= mar_pkg::FREQ_RESET;
      min_head_r   <= mar_pkg::MIN_HEAD_RESET;
      max_head_r   <= mar_pkg::MAX_HEAD_RESET;
      vgain_r      <= '0;
      cgain_r      <= '0;
      range_r      <= mar_pkg::RANGE_100R;
      ranging_on_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mar_pkg::CFG_FREQUENCY:   freq_r     <= cfg_data;
          mar_pkg::CFG_MIN_HEAD:    min_head_r <= cfg_data[13:0];
          mar_pkg::CFG_MAX_HEAD:    max_head_r <= cfg_data[13:0];
          mar_pkg::CFG_MIN_AVERAGE: ;
          default: ;
        endcase
      end
      if (commit) begin
        vgain_r      <= vgain_nxt;
        cgain_r      <= cgain_nxt;
        range_r      <= range_nxt;
        ranging_on_r <= ranging_on_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "meter_autorange_controller_assert.svh"

  `MAR_ASSERT_NXT(a_busy_after_accept, in_accept, state_r == ST_RUN)
  `MAR_ASSERT_IMP(a_done_only_in_run, div_st.done, state_r == ST_RUN)
  `MAR_ASSERT_IMP(a_head_before_div, div_st.done, !head_st.busy)
  `MAR_ASSERT_NXT(a_start_sets_ranging, commit && status == mar_pkg::STAT_STARTED, ranging_on_r)
  `MAR_ASSERT_NXT(a_finish_clears, commit && status == mar_pkg::STAT_FINISHED, !ranging_on_r)

endmodule
`default_nettype wire
